### hdl/rcpe_pkg.sv
package rcpe_pkg;

    // Grid geometry: data bit (r*GRID_SIDE + c) sits at row r, column c
    localparam int GRID_SIDE = 7;

    localparam int CHUNK_W = 56;
    localparam int CODE_W  = 64;
    localparam int DATA_W  = GRID_SIDE * GRID_SIDE;
    localparam int PAR_W   = 2 * GRID_SIDE + 1;

    // Spare bits that each chunk leaves over for the next word
    localparam int SPARE_PER_CHUNK = CHUNK_W - DATA_W;

    // Index of the chunk that closes a run (two codewords come out of it)
    localparam int LAST_PHASE = (DATA_W + SPARE_PER_CHUNK - 1) / SPARE_PER_CHUNK - 1;
    localparam int PHASE_W    = 3;

    typedef logic [CHUNK_W-1:0] chunk_t;
    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [DATA_W-1:0]  data_t;
    typedef logic [PHASE_W-1:0] phase_t;

endpackage

### hdl/rcpe_ifs.sv
interface rcpe_in_if;
    logic                   valid;
    logic                   ready;
    rcpe_pkg::chunk_t       chunk_bits;

    modport source (output valid, output chunk_bits, input ready);
    modport sink   (input valid, input chunk_bits, output ready);
endinterface

interface rcpe_out_if;
    logic                   valid;
    logic                   ready;
    rcpe_pkg::code_t        codeword;
    logic                   last_of_run;

    modport source (output valid, output codeword, output last_of_run, input ready);
    modport sink   (input valid, input codeword, input last_of_run, output ready);
endinterface

### hdl/rcpe_parity.sv
module rcpe_parity (
    input  rcpe_pkg::data_t data,
    output rcpe_pkg::code_t codeword
);

    logic [rcpe_pkg::GRID_SIDE-1:0] row_par;
    logic [rcpe_pkg::GRID_SIDE-1:0] col_par;
    logic                           corner;

    // Row and column parities over the grid, corner over the column parities
    always_comb
    begin
        row_par = '0;
        col_par = '0;
        for (int r = 0; r < rcpe_pkg::GRID_SIDE; r++)
        begin
            for (int c = 0; c < rcpe_pkg::GRID_SIDE; c++)
            begin
                row_par[r] = row_par[r] ^ data[r * rcpe_pkg::GRID_SIDE + c];
                col_par[r] = col_par[r] ^ data[c * rcpe_pkg::GRID_SIDE + r];
            end
        end
        corner = ^col_par;
    end

    // Data low, parity above, filling the codeword width exactly
    assign codeword = rcpe_pkg::CODE_W'({corner, col_par, row_par, data});

endmodule

### hdl/row_column_parity_encoder.sv
// Two-dimensional row/column parity encoder. Each accepted 56-bit chunk
// (first byte in bits 7:0) is regrouped with bits held from earlier chunks
// into a 49-bit data word, which leaves as a 64-bit codeword with 7 row
// parities, 7 column parities and a corner parity in bits 63:49. The seventh
// chunk of a run also releases the held bits as a second codeword, then the
// run restarts. last_of_run marks the final codeword caused by each chunk.
// Throughput is one chunk per cycle while the output is not stalled; the
// seventh chunk of a run holds the input stage while its second codeword
// moves into the output register. A chunk's first codeword passes through
// the input stage and then the output register.
module row_column_parity_encoder (
    input  logic              clk,
    input  logic              rst_n,
    rcpe_in_if.sink           chunk_ch,
    rcpe_out_if.source        code_ch
);

    // Run state
    rcpe_pkg::phase_t phase_reg;
    rcpe_pkg::data_t  spare_reg;

    // Word stage
    logic             a_valid_reg;
    logic             a_two_reg;
    logic             a_sub_reg;
    rcpe_pkg::data_t  a_data_reg;
    rcpe_pkg::data_t  a_extra_reg;

    // Output register
    logic             o_valid_reg;
    logic             o_last_reg;
    rcpe_pkg::code_t  o_code_reg;

    logic             in_fire;
    logic             o_load;
    logic             a_done;
    logic             is_final;
    rcpe_pkg::data_t  word_next;
    rcpe_pkg::data_t  spare_next;
    rcpe_pkg::data_t  a_word;
    rcpe_pkg::code_t  o_code_next;

    // Handshake
    assign in_fire  = chunk_ch.valid && chunk_ch.ready;
    assign o_load   = a_valid_reg && (!o_valid_reg || code_ch.ready);
    assign a_done   = o_load && (!a_two_reg || a_sub_reg);
    assign chunk_ch.ready = !a_valid_reg || a_done;

    assign is_final = (phase_reg == rcpe_pkg::phase_t'(rcpe_pkg::LAST_PHASE));

    // Regroup: held bits lead, top of the chunk follows; low chunk bits are held
    always_comb
    begin
        word_next  = '0;
        spare_next = '0;
        for (int p = 0; p <= rcpe_pkg::LAST_PHASE; p++)
        begin
            if (phase_reg == rcpe_pkg::phase_t'(p))
            begin
                word_next = rcpe_pkg::DATA_W'(chunk_ch.chunk_bits >>
                                ((p + 1) * rcpe_pkg::SPARE_PER_CHUNK))
                          | (spare_reg << (rcpe_pkg::DATA_W
                                - p * rcpe_pkg::SPARE_PER_CHUNK));
                spare_next = rcpe_pkg::DATA_W'(chunk_ch.chunk_bits
                          & ({rcpe_pkg::CHUNK_W{1'b1}} >> (rcpe_pkg::CHUNK_W
                                - (p + 1) * rcpe_pkg::SPARE_PER_CHUNK)));
            end
        end
    end

    // Advance run state and word stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            spare_reg   <= '0;
            a_valid_reg <= 1'b0;
            a_two_reg   <= 1'b0;
            a_sub_reg   <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                a_valid_reg <= 1'b1;
                a_two_reg   <= is_final;
                a_sub_reg   <= 1'b0;
                if (is_final)
                begin
                    phase_reg <= '0;
                    spare_reg <= '0;
                end
                else
                begin
                    phase_reg <= phase_reg + 1'b1;
                    spare_reg <= spare_next;
                end
            end
            else if (a_done)
            begin
                a_valid_reg <= 1'b0;
            end
            else if (o_load)
            begin
                a_sub_reg <= 1'b1;
            end
        end
    end

    // Hold word stage payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_data_reg  <= word_next;
            a_extra_reg <= spare_next;
        end
    end

    // Encode the pending word
    assign a_word = a_sub_reg ? a_extra_reg : a_data_reg;

    rcpe_parity u_parity (
        .data     (a_word),
        .codeword (o_code_next)
    );

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_load)
        begin
            o_valid_reg <= 1'b1;
        end
        else if (code_ch.ready)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (o_load)
        begin
            o_code_reg <= o_code_next;
            o_last_reg <= !a_two_reg || a_sub_reg;
        end
    end

    assign code_ch.valid       = o_valid_reg;
    assign code_ch.codeword    = o_code_reg;
    assign code_ch.last_of_run = o_last_reg;

endmodule

### hdl/rcpe_check.sv
module rcpe_check (
    input logic            clk,
    input logic            rst_n,
    input logic            out_valid,
    input logic            out_ready,
    input rcpe_pkg::code_t codeword,
    input logic            last_of_run
);

    localparam int ROW_LO = rcpe_pkg::DATA_W;
    localparam int COL_LO = rcpe_pkg::DATA_W + rcpe_pkg::GRID_SIDE;
    localparam int CORNER = rcpe_pkg::DATA_W + 2 * rcpe_pkg::GRID_SIDE;

    logic out_fire;
    assign out_fire = out_valid && out_ready;

    // Stalled item holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(codeword) && $stable(last_of_run))
        else $error("codeword changed while stalled");

    // Corner parity agrees with both the row and the column parities
    a_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (^codeword[ROW_LO +: rcpe_pkg::GRID_SIDE]) == codeword[CORNER]
                   && (^codeword[COL_LO +: rcpe_pkg::GRID_SIDE]) == codeword[CORNER])
        else $error("corner parity mismatch");

    // The second codeword of a chunk follows its first without a gap
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !last_of_run |=> out_valid && last_of_run)
        else $error("second codeword of a chunk missing");

endmodule

bind row_column_parity_encoder rcpe_check u_rcpe_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (code_ch.valid),
    .out_ready   (code_ch.ready),
    .codeword    (code_ch.codeword),
    .last_of_run (code_ch.last_of_run)
);
